### rtl/core/dspc_pkg.sv
package dspc_pkg;

	localparam int BYTE_W  = 8;
	localparam int WIN_W   = 16;
	localparam int CNT_W   = 17;
	localparam int HIT_W   = 4;
	localparam int REC_W   = 6;
	localparam int MODE_W  = 2;
	localparam int TDATA_W = 32;

	localparam int MAX_RECORDS_DEF = 32;

	localparam logic [MODE_W-1:0] MODE_GCR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MFM = 2'd1;

	localparam logic [9:0]       GCR_WORD   = 10'h3FF;
	localparam logic [WIN_W-1:0] MFM_WORD   = 16'h4489;
	localparam logic [CNT_W:0]   GCR_EXPECT = 18'd21;
	localparam logic [CNT_W:0]   MFM_EXPECT = 18'd11;
	localparam logic [CNT_W:0]   SYNC_TOL   = 18'd2;
	localparam logic [CNT_W-1:0] COUNT_MAX  = 17'h1FFFF;

	typedef struct packed {
		logic              start_scan;
		logic              last_byte;
		logic [BYTE_W-1:0] data_byte;
	} item_t;

	typedef struct packed {
		logic              bad_platform;
		logic              any_anomaly;
		logic [REC_W-1:0]  anomaly_records;
		logic              anomaly_stored;
		logic              anomaly;
		logic [CNT_W-1:0]  sync_count;
	} result_t;

endpackage

### rtl/core/disk_sync_pattern_counter_top.sv
// the last beat of a track goes through the input stage, then the result register
// one beat per cycle unless a last beat stalls; the window and count update per byte
// back pressure on the result side stalls only last beats held in the input stage
// reset (arst_n low, asynchronous): mode 0, window, count, records and sticky flag cleared
module disk_sync_pattern_counter_top #(
	parameter int MAX_RECORDS = dspc_pkg::MAX_RECORDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [dspc_pkg::MODE_W-1:0]  cfg_wdata,     // platform_mode
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [dspc_pkg::BYTE_W-1:0]  s_axis_tdata,  // data_byte
	input  logic                         s_axis_tlast,  // last_byte
	input  logic                         s_axis_tuser,  // start_scan
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// sync_count, anomaly, anomaly_stored, anomaly_records, any_anomaly, zero fill
	output logic [dspc_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic                         m_axis_tuser   // bad_platform
);

	logic [dspc_pkg::MODE_W-1:0] mode_q;
	logic                        valid_s1;
	dspc_pkg::item_t             item_s1;
	logic                        fire;
	dspc_pkg::result_t           res;
	logic                        m_valid_q;
	dspc_pkg::result_t           res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= dspc_pkg::MODE_GCR;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	assign fire          = valid_s1 && (!item_s1.last_byte || !m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= '{start_scan: s_axis_tuser, last_byte: s_axis_tlast,
			             data_byte: s_axis_tdata};
		end
	end

	dspc_scan_core #(
		.MAX_RECORDS (MAX_RECORDS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (fire),
		.item   (item_s1),
		.mode   (mode_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire && item_s1.last_byte) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && item_s1.last_byte) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = dspc_pkg::TDATA_W'({res_q.any_anomaly, res_q.anomaly_records,
	                        res_q.anomaly_stored, res_q.anomaly, res_q.sync_count});
	assign m_axis_tuser  = res_q.bad_platform;

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_q.bad_platform |-> m_axis_tdata == '0)
		else $error("bad platform beat carries nonzero data");

	a_stored_anom: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_q.anomaly_stored |-> res_q.anomaly)
		else $error("record stored without anomaly");

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_q.anomaly |-> res_q.any_anomaly)
		else $error("anomaly without sticky flag");

	a_rec_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> res_q.anomaly_records <= dspc_pkg::REC_W'(MAX_RECORDS))
		else $error("record count above limit");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_axis_tready |=> m_valid_q && $stable(res_q))
		else $error("stalled result beat changed");

endmodule

### rtl/core/dspc_hit_count.sv
module dspc_hit_count (
	input  logic [dspc_pkg::WIN_W-1:0]  window,
	input  logic [dspc_pkg::BYTE_W-1:0] data_byte,
	input  logic [dspc_pkg::MODE_W-1:0] mode,
	output logic [dspc_pkg::HIT_W-1:0]  hits
);

	logic [dspc_pkg::WIN_W+dspc_pkg::BYTE_W-1:0] bits;
	logic [dspc_pkg::BYTE_W-1:0]                 match;

	assign bits = {window, data_byte};

	// one window position per consumed bit, oldest position in the top
	always_comb begin
		for (int i = 0; i < dspc_pkg::BYTE_W; i++) begin
			if (mode == dspc_pkg::MODE_GCR) begin
				match[i] = (bits[i +: 10] == dspc_pkg::GCR_WORD);
			end else begin
				match[i] = (bits[i +: dspc_pkg::WIN_W] == dspc_pkg::MFM_WORD);
			end
		end
	end

	always_comb begin
		hits = '0;
		for (int i = 0; i < dspc_pkg::BYTE_W; i++) begin
			hits = hits + dspc_pkg::HIT_W'(match[i]);
		end
	end

endmodule

### rtl/core/dspc_scan_core.sv
module dspc_scan_core #(
	parameter int MAX_RECORDS = dspc_pkg::MAX_RECORDS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  dspc_pkg::item_t             item,
	input  logic [dspc_pkg::MODE_W-1:0] mode,
	output dspc_pkg::result_t           res
);

	localparam logic [dspc_pkg::REC_W-1:0] REC_LIMIT = dspc_pkg::REC_W'(MAX_RECORDS);

	logic [dspc_pkg::WIN_W-1:0] window_q;
	logic [dspc_pkg::CNT_W-1:0] total_q;
	logic [dspc_pkg::REC_W-1:0] rec_q;
	logic                       sticky_q;

	logic [dspc_pkg::HIT_W-1:0] hits;
	logic                       supported;
	logic [dspc_pkg::CNT_W:0]   sum;
	logic [dspc_pkg::CNT_W-1:0] total_new;
	logic [dspc_pkg::CNT_W:0]   total_ext;
	logic [dspc_pkg::CNT_W:0]   expect_cnt;
	logic                       anom;
	logic                       stored;
	logic [dspc_pkg::REC_W-1:0] rec_base;
	logic [dspc_pkg::REC_W-1:0] rec_new;
	logic                       sticky_base;
	logic                       sticky_new;

	dspc_hit_count u_hit (
		.window    (window_q),
		.data_byte (item.data_byte),
		.mode      (mode),
		.hits      (hits)
	);

	always_comb begin
		supported   = (mode == dspc_pkg::MODE_GCR) || (mode == dspc_pkg::MODE_MFM);
		sum         = {1'b0, total_q} + (dspc_pkg::CNT_W+1)'(hits);
		total_new   = total_q;
		if (supported) begin
			total_new = sum[dspc_pkg::CNT_W] ? dspc_pkg::COUNT_MAX : sum[dspc_pkg::CNT_W-1:0];
		end
		total_ext   = {1'b0, total_new};
		expect_cnt  = (mode == dspc_pkg::MODE_GCR) ? dspc_pkg::GCR_EXPECT : dspc_pkg::MFM_EXPECT;
		anom        = supported && ((total_ext > expect_cnt + dspc_pkg::SYNC_TOL) ||
		                            (total_ext + dspc_pkg::SYNC_TOL < expect_cnt));
		rec_base    = item.start_scan ? '0 : rec_q;
		sticky_base = item.start_scan ? 1'b0 : sticky_q;
		stored      = anom && (rec_base < REC_LIMIT);
		rec_new     = rec_base + dspc_pkg::REC_W'(stored);
		sticky_new  = sticky_base | anom;

		res = '0;
		if (supported) begin
			res.sync_count      = total_new;
			res.anomaly         = anom;
			res.anomaly_stored  = stored;
			res.anomaly_records = rec_new;
			res.any_anomaly     = sticky_new;
		end else begin
			res.bad_platform = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			total_q  <= '0;
			rec_q    <= '0;
			sticky_q <= 1'b0;
		end else if (step) begin
			if (item.last_byte) begin
				window_q <= '0;
				total_q  <= '0;
				rec_q    <= supported ? rec_new : rec_base;
				sticky_q <= supported ? sticky_new : sticky_base;
			end else begin
				if (supported) begin
					window_q <= {window_q[dspc_pkg::BYTE_W-1:0], item.data_byte};
				end
				total_q  <= total_new;
				rec_q    <= rec_base;
				sticky_q <= sticky_base;
			end
		end
	end

endmodule
